// File: hw/rtl/wfm_pkg.sv
// Shared constants and types for the wildcard file-name matcher.
// No dependencies; imported by wildcard_filename_matcher_unit.
package wfm_pkg;

    localparam int MAX_PATTERN  = 56;
    localparam int NAME_LIMIT   = 255;
    localparam int PATTERN_REGS = 7;

    localparam logic [7:0] STAR  = 8'h2A;
    localparam logic [7:0] SLASH = 8'h2F;

    // Register indexes on the configuration port (paddr[5:3]).
    localparam logic [2:0] REG_PATTERN_LENGTH  = 3'd0;
    localparam logic [2:0] REG_PATTERN_BYTES_0 = 3'd1;

    typedef enum logic [2:0] {
        MODE_ALL,
        MODE_SUB,
        MODE_SUFFIX,
        MODE_PREFIX,
        MODE_EXACT
    } mode_t;

endpackage

// File: hw/rtl/wildcard_filename_matcher_unit.sv
// A last byte goes to the input stage, then its result to the result register.
// Throughput: one path byte per cycle, sustained, as long as results are taken.
// Reset (rst_n, asynchronous, active low) clears the pattern registers, the
// name count and flags, and both valid flags; no clearing pass is needed.
// The rate is set by the single input stage feeding the compare stage.
// Depends on wfm_pkg.
module wildcard_filename_matcher_unit
    import wfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Path byte channel.
    input  logic        path_valid,
    output logic        path_ready,
    input  logic [7:0]  path_byte,
    input  logic        last_byte,
    // Result channel.
    output logic        result_valid,
    input  logic        result_ready,
    output logic        matched,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Each register occupies 8 bytes, so the
    // register index is paddr[5:3].
    // ------------------------------------------------------------------
    logic [5:0]  pattern_length_reg;
    logic [63:0] pattern_bytes_reg [PATTERN_REGS];
    logic [2:0]  cfg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[5:3];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            for (int r = 0; r < PATTERN_REGS; r++)
            begin
                pattern_bytes_reg[r] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_PATTERN_LENGTH)
            begin
                pattern_length_reg <= pwdata[5:0];
            end
            else
            begin
                pattern_bytes_reg[cfg_index - REG_PATTERN_BYTES_0] <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PATTERN_LENGTH: prdata = {58'd0, pattern_length_reg};
            default:            prdata = pattern_bytes_reg[cfg_index - REG_PATTERN_BYTES_0];
        endcase
    end

    // ------------------------------------------------------------------
    // Quasi-static pattern decode beside the datapath. The user must keep the
    // pattern static while transactions are in flight; not enforced here.
    // ------------------------------------------------------------------
    logic [7:0] pat [MAX_PATTERN];

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat[i] = pattern_bytes_reg[i >> 3][(i & 7) * 8 +: 8];
        end
    end

    // Guarded lookup: positions beyond the pattern store read as zero.
    function automatic logic [7:0] pat_at(input logic [5:0] idx,
                                          input logic [7:0] bytes [MAX_PATTERN]);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 6'(MAX_PATTERN))
        begin
            b = bytes[idx];
        end
        return b;
    endfunction

    logic [5:0] len_eff;
    logic       lead_star;
    logic       trail_star;
    mode_t      mode;
    logic       text_start;
    logic [5:0] text_len;

    always_comb
    begin
        len_eff = (pattern_length_reg > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN)
                                                         : pattern_length_reg;
        lead_star  = (len_eff != 6'd0) && (pat[0] == STAR);
        trail_star = (len_eff != 6'd0) && (pat_at(len_eff - 6'd1, pat) == STAR);

        text_start = 1'b0;
        text_len   = len_eff;
        if (len_eff == 6'd0)
        begin
            mode = MODE_EXACT;
        end
        else if (len_eff == 6'd1 && lead_star)
        begin
            mode = MODE_ALL;
        end
        else if (lead_star && trail_star)
        begin
            mode       = MODE_SUB;
            text_start = 1'b1;
            text_len   = len_eff - 6'd2;
        end
        else if (lead_star)
        begin
            mode       = MODE_SUFFIX;
            text_start = 1'b1;
            text_len   = len_eff - 6'd1;
        end
        else if (trail_star)
        begin
            mode     = MODE_PREFIX;
            text_len = len_eff - 6'd1;
        end
        else
        begin
            mode = MODE_EXACT;
        end
    end

    // The pattern text reversed so that entry k lines up with window
    // entry k (newest byte first) when the name ends with the text.
    logic [7:0] aligned [MAX_PATTERN];

    always_comb
    begin
        logic [6:0] idx;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx = 7'(text_start) + 7'(text_len) - 7'd1 - 7'(k);
            aligned[k] = pat_at(idx[5:0], pat);
        end
    end

    // ------------------------------------------------------------------
    // Input stage: one registered path byte.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       stage_go;
    logic       result_valid_reg;
    logic       matched_reg;

    // A byte that is not the last of its path produces no result, so it
    // moves on even while a result is waiting to be taken.
    assign stage_go   = in_valid_reg &
                        (~in_last_reg | ~result_valid_reg | result_ready);
    assign path_ready = ~in_valid_reg | stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (path_ready)
        begin
            in_valid_reg <= path_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_valid && path_ready)
        begin
            in_byte_reg <= path_byte;
            in_last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Name state and compare stage.
    // ------------------------------------------------------------------
    logic [7:0] window_reg [MAX_PATTERN];
    logic [7:0] window_next [MAX_PATTERN];
    logic [7:0] name_count_reg;
    logic [7:0] name_count_next;
    logic       prefix_ok_reg;
    logic       prefix_ok_next;
    logic       seen_reg;
    logic       seen_next;
    logic       is_slash;
    logic       prefix_fail;
    logic       tail_equal;
    logic       match_now;

    assign is_slash = (in_byte_reg == SLASH);

    always_comb
    begin
        // Prefix and exact modes check each byte against its own position.
        prefix_fail = ((mode == MODE_PREFIX) || (mode == MODE_EXACT)) &&
                      (name_count_reg < {2'b00, text_len}) &&
                      (in_byte_reg != pat_at(name_count_reg[5:0], pat));

        if (is_slash)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_next[k] = window_reg[k];
            end
            name_count_next = 8'd0;
            prefix_ok_next  = 1'b1;
        end
        else
        begin
            window_next[0] = in_byte_reg;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                window_next[k] = window_reg[k - 1];
            end
            name_count_next = (name_count_reg < 8'(NAME_LIMIT)) ? name_count_reg + 8'd1
                                                               : name_count_reg;
            prefix_ok_next  = prefix_ok_reg & ~prefix_fail;
        end

        // Entries at or beyond the name length are never looked at, so a
        // cleared name needs only its count reset.
        tail_equal = ({2'b00, text_len} <= name_count_next);
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ((6'(k) < text_len) && (window_next[k] != aligned[k]))
            begin
                tail_equal = 1'b0;
            end
        end

        if (is_slash)
        begin
            seen_next = 1'b0;
        end
        else
        begin
            seen_next = seen_reg |
                        ((mode == MODE_SUB) && (text_len != 6'd0) && tail_equal);
        end

        case (mode)
            MODE_ALL:    match_now = 1'b1;
            MODE_SUB:    match_now = (text_len == 6'd0) || seen_next;
            MODE_SUFFIX: match_now = tail_equal;
            MODE_PREFIX: match_now = (name_count_next >= {2'b00, text_len}) &&
                                     prefix_ok_next;
            default:     match_now = (name_count_next == {2'b00, text_len}) &&
                                     prefix_ok_next;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_go)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    // After the last byte of a path the name state returns to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_count_reg <= 8'd0;
            prefix_ok_reg  <= 1'b1;
            seen_reg       <= 1'b0;
        end
        else if (stage_go)
        begin
            if (in_last_reg)
            begin
                name_count_reg <= 8'd0;
                prefix_ok_reg  <= 1'b1;
                seen_reg       <= 1'b0;
            end
            else
            begin
                name_count_reg <= name_count_next;
                prefix_ok_reg  <= prefix_ok_next;
                seen_reg       <= seen_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. It holds one finished transaction while new path
    // bytes keep flowing through the compare stage.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stage_go && in_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && in_last_reg)
        begin
            matched_reg <= match_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

endmodule
